### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge outside reset
`define BDLP_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("bdlp assertion failed");

// checked on every rising clock edge, reset included
`define BDLP_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) (prop)) \
      else $error("bdlp assertion failed");

`endif

### design/bdlp_pkg.sv
`timescale 1ns / 1ps

package bdlp_pkg;

   // button table
   localparam int NUM_BUTTONS = 8;
   localparam int BTN_W       = 3;

   // field and register widths
   localparam int KIND_W     = 2;
   localparam int DEBOUNCE_W = 16;
   localparam int TICK_W     = 10;
   localparam int SEC_W      = 8;
   localparam int HOLD_W     = 18;
   localparam int LIMIT_W    = 18;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // event kinds
   localparam logic [KIND_W-1:0] KIND_PRESS      = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LONG_PRESS = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LONG_CLICK = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CLICK      = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_MS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS_SEC = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_MS        = 2'd2;

   // reset values
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 16'd20;
   localparam logic [SEC_W-1:0]      LONG_SEC_RST = 8'd2;
   localparam logic [TICK_W-1:0]     TICK_RST     = 10'd10;

   localparam int MS_PER_SEC = 1000;
   localparam logic [HOLD_W-1:0] HOLD_MAX = {HOLD_W{1'b1}};

   // event queue
   localparam int FIFO_AW    = 3;
   localparam int FIFO_DEPTH = 1 << FIFO_AW;
   localparam int FIFO_CW    = FIFO_AW + 1;
   // room for the item in the stage and one more, two events each
   localparam int FIFO_ACCEPT_MAX = FIFO_DEPTH - 4;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BTN_W-1:0]  button;
      logic              last;
   } event_type;

endpackage

### design/bdlp_req_if.sv
`timescale 1ns / 1ps

interface bdlp_req_if;
   import bdlp_pkg::*;

   logic             valid;
   logic             ready;
   logic [BTN_W-1:0] button_index;
   logic             pressed;

   modport source (output valid, output button_index, output pressed, input ready);
   modport sink (input valid, input button_index, input pressed, output ready);
endinterface

### design/bdlp_rsp_if.sv
`timescale 1ns / 1ps

interface bdlp_rsp_if;
   import bdlp_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] event_kind;
   logic [BTN_W-1:0]  event_button;
   logic              last;

   modport source (output valid, output event_kind, output event_button, output last,
                   input ready);
   modport sink (input valid, input event_kind, input event_button, input last,
                 output ready);
endinterface

### design/button_debounce_long_press.sv
`timescale 1ns / 1ps
// A request accepted on req is held in the stage register and evaluated there; its events
// are written into the event queue and offered on rsp from the queue.
// Throughput: one request per cycle while the event queue holds at most four events;
// events leave the eight-entry queue at one per cycle while rsp is ready, so two-event requests drain at half rate.
// Reset clears the button table, the stage and the queue and restores register defaults.

module button_debounce_long_press (
   input  logic                               clock,
   input  logic                               reset,
   bdlp_req_if.sink                           req_if,
   bdlp_rsp_if.source                         rsp_if,
   input  logic                               csr_we,
   input  logic [bdlp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bdlp_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import bdlp_pkg::*;

   `include "assert_macros.svh"

   // configuration
   logic [DEBOUNCE_W-1:0] debounce_ff;
   logic [LIMIT_W-1:0]    long_limit_ff;
   logic [TICK_W-1:0]     tick_ff;

   // button table
   logic                  held_ff       [NUM_BUTTONS];
   logic                  bouncing_ff   [NUM_BUTTONS];
   logic [DEBOUNCE_W-1:0] bounce_left_ff[NUM_BUTTONS];
   logic [HOLD_W-1:0]     hold_time_ff  [NUM_BUTTONS];
   logic                  long_fired_ff [NUM_BUTTONS];

   // input stage
   logic             st_valid_ff;
   logic [BTN_W-1:0] st_idx_ff;
   logic             st_pressed_ff;

   // event queue
   event_type          fifo_ff[FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff;
   logic [FIFO_AW-1:0] rd_ptr_ff;
   logic [FIFO_CW-1:0] count_ff;
   logic [FIFO_CW-1:0] count_in;

   logic req_accept;
   logic rsp_pop;

   // next state of the button in the stage
   logic                  held_in;
   logic                  bouncing_in;
   logic [DEBOUNCE_W-1:0] bounce_left_in;
   logic [HOLD_W-1:0]     hold_time_in;
   logic                  long_fired_in;
   logic [1:0]            n_ev;
   event_type             ev_a;
   event_type             ev_b;

   logic                  in_range;
   logic [HOLD_W:0]       hold_sum;
   logic [HOLD_W-1:0]     hold_sat;

   assign req_accept   = req_if.valid && req_if.ready;
   assign rsp_pop      = rsp_if.valid && rsp_if.ready;
   assign req_if.ready = (count_ff <= FIFO_CW'(FIFO_ACCEPT_MAX));

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DEBOUNCE_RST;
         long_limit_ff <= LIMIT_W'(LONG_SEC_RST) * LIMIT_W'(MS_PER_SEC);
         tick_ff       <= TICK_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEBOUNCE_MS: debounce_ff <= csr_wdata;
            CSR_LONG_PRESS_SEC: begin
               long_limit_ff <= LIMIT_W'(csr_wdata[SEC_W-1:0]) * LIMIT_W'(MS_PER_SEC);
            end
            CSR_TICK_MS: tick_ff <= csr_wdata[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff <= 1'b0;
      end else begin
         st_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         st_idx_ff     <= req_if.button_index;
         st_pressed_ff <= req_if.pressed;
      end
   end

   assign in_range = (int'(st_idx_ff) < NUM_BUTTONS);
   assign hold_sum = {1'b0, hold_time_ff[st_idx_ff]} + (HOLD_W + 1)'(tick_ff);
   assign hold_sat = hold_sum[HOLD_W] ? HOLD_MAX : hold_sum[HOLD_W-1:0];

   // per-button debounce and long-press update
   always_comb begin
      held_in        = held_ff[st_idx_ff];
      bouncing_in    = bouncing_ff[st_idx_ff];
      bounce_left_in = bounce_left_ff[st_idx_ff];
      hold_time_in   = hold_time_ff[st_idx_ff];
      long_fired_in  = long_fired_ff[st_idx_ff];
      n_ev           = 2'd0;
      ev_a           = '{kind: KIND_CLICK, button: st_idx_ff, last: 1'b1};
      ev_b           = '{kind: KIND_CLICK, button: st_idx_ff, last: 1'b1};
      if (st_pressed_ff) begin
         if (!held_ff[st_idx_ff]) begin
            // new press starts the bounce check
            held_in        = 1'b1;
            bouncing_in    = 1'b1;
            bounce_left_in = debounce_ff;
         end else if (bouncing_ff[st_idx_ff]) begin
            if (bounce_left_ff[st_idx_ff] > DEBOUNCE_W'(tick_ff)) begin
               bounce_left_in = bounce_left_ff[st_idx_ff] - DEBOUNCE_W'(tick_ff);
            end else begin
               bouncing_in = 1'b0;
               n_ev        = 2'd1;
               ev_a.kind   = KIND_PRESS;
            end
         end else if ((long_limit_ff != '0) && !long_fired_ff[st_idx_ff]) begin
            // count held time until the long-press limit
            hold_time_in = hold_sat;
            if (hold_sat >= long_limit_ff) begin
               long_fired_in = 1'b1;
               n_ev          = 2'd1;
               ev_a.kind     = KIND_LONG_PRESS;
            end
         end
      end else if (held_ff[st_idx_ff]) begin
         held_in     = 1'b0;
         bouncing_in = 1'b0;
         if (!bouncing_ff[st_idx_ff]) begin
            // confirmed release
            bounce_left_in = '0;
            hold_time_in   = '0;
            long_fired_in  = 1'b0;
            if (long_fired_ff[st_idx_ff]) begin
               n_ev      = 2'd2;
               ev_a.kind = KIND_LONG_CLICK;
               ev_a.last = 1'b0;
            end else begin
               n_ev = 2'd1;
            end
         end
      end
      if (!st_valid_ff || !in_range) begin
         n_ev = 2'd0;
      end
   end

   // button table write-back
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            held_ff[i]        <= 1'b0;
            bouncing_ff[i]    <= 1'b0;
            bounce_left_ff[i] <= '0;
            hold_time_ff[i]   <= '0;
            long_fired_ff[i]  <= 1'b0;
         end
      end else if (st_valid_ff && in_range) begin
         held_ff[st_idx_ff]        <= held_in;
         bouncing_ff[st_idx_ff]    <= bouncing_in;
         bounce_left_ff[st_idx_ff] <= bounce_left_in;
         hold_time_ff[st_idx_ff]   <= hold_time_in;
         long_fired_ff[st_idx_ff]  <= long_fired_in;
      end
   end

   // event queue storage
   always_ff @(posedge clock) begin
      if (n_ev != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= ev_a;
      end
      if (n_ev == 2'd2) begin
         fifo_ff[wr_ptr_ff + FIFO_AW'(1)] <= ev_b;
      end
   end

   assign count_in = count_ff + FIFO_CW'(n_ev) - FIFO_CW'(rsp_pop);

   // event queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + FIFO_AW'(n_ev);
         rd_ptr_ff <= rd_ptr_ff + FIFO_AW'(rsp_pop);
         count_ff  <= count_in;
      end
   end

   assign rsp_if.valid        = (count_ff != '0);
   assign rsp_if.event_kind   = fifo_ff[rd_ptr_ff].kind;
   assign rsp_if.event_button = fifo_ff[rd_ptr_ff].button;
   assign rsp_if.last         = fifo_ff[rd_ptr_ff].last;

   // checks
   `BDLP_ASSERT_ALWAYS(a_reset_clears_queue, reset |=> (count_ff == '0))
   `BDLP_ASSERT(a_fifo_bound, count_ff <= FIFO_CW'(FIFO_DEPTH))
   `BDLP_ASSERT(a_bounce_needs_held, st_valid_ff |-> (!bouncing_ff[st_idx_ff] || held_ff[st_idx_ff]))
   `BDLP_ASSERT(a_long_not_bouncing, st_valid_ff |-> !(long_fired_ff[st_idx_ff] && bouncing_ff[st_idx_ff]))

endmodule

### test/button_debounce_long_press_test.sv
`timescale 1ns / 1ps

module button_debounce_long_press_test;
   import bdlp_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int NUM_PHASES   = 9;
   localparam int HOLD_CYCLES  = 120;
   localparam int SETTLE       = 4;
   localparam int END_WAIT     = 8;
   localparam int QUIET_LIMIT  = 3000;
   localparam int PRESSURE_PH  = 4;
   localparam int NOISE_PCT    = 8;
   localparam int MAX_PRESS    = 300;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct {
      int            deb;
      int            sec;
      int            tick;
      int            buttons;
      int            items;
      idle_mode_type idle;
   } phase_plan_type;

   // per-button debounce state and the events each sample should produce
   class button_event_predictor;
      logic [DEBOUNCE_W-1:0] cfg_debounce;
      logic [SEC_W-1:0]      cfg_long_sec;
      logic [TICK_W-1:0]     cfg_tick;
      bit                    is_down[NUM_BUTTONS];
      bit                    in_bounce[NUM_BUTTONS];
      logic [DEBOUNCE_W-1:0] bounce_rem[NUM_BUTTONS];
      logic [HOLD_W-1:0]     held_ms[NUM_BUTTONS];
      bit                    long_sent[NUM_BUTTONS];
      event_type             due_events[$];
      int                    mismatches;
      int                    failures;

      function new();
         cfg_debounce = DEBOUNCE_RST;
         cfg_long_sec = LONG_SEC_RST;
         cfg_tick     = TICK_RST;
         foreach (is_down[i]) begin
            is_down[i]    = 1'b0;
            in_bounce[i]  = 1'b0;
            bounce_rem[i] = '0;
            held_ms[i]    = '0;
            long_sent[i]  = 1'b0;
         end
         mismatches = 0;
         failures   = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_DEBOUNCE_MS:    cfg_debounce = data[DEBOUNCE_W-1:0];
            CSR_LONG_PRESS_SEC: cfg_long_sec = data[SEC_W-1:0];
            CSR_TICK_MS:        cfg_tick = data[TICK_W-1:0];
            default: ;
         endcase
      endfunction

      function void add_event(logic [KIND_W-1:0] k, logic [BTN_W-1:0] b);
         due_events.push_back('{kind: k, button: b, last: 1'b0});
      endfunction

      function void note_sample(logic [BTN_W-1:0] b, logic p);
         int first;
         int rem;
         int t;
         first = due_events.size();
         if (p) begin
            if (!is_down[b]) begin
               // first pressed sample starts the bounce check
               is_down[b]    = 1'b1;
               in_bounce[b]  = 1'b1;
               bounce_rem[b] = cfg_debounce;
            end else if (in_bounce[b]) begin
               // signed countdown, confirm once the remainder is used up
               rem = int'(bounce_rem[b]) - int'(cfg_tick);
               if (rem > 0) begin
                  bounce_rem[b] = rem[DEBOUNCE_W-1:0];
               end else begin
                  in_bounce[b] = 1'b0;
                  add_event(KIND_PRESS, b);
               end
            end else if (cfg_long_sec != 0 && !long_sent[b]) begin
               // saturating hold time toward the long press threshold
               t = int'(held_ms[b]) + int'(cfg_tick);
               if (t > int'(HOLD_MAX)) t = int'(HOLD_MAX);
               held_ms[b] = t[HOLD_W-1:0];
               if (t >= int'(cfg_long_sec) * MS_PER_SEC) begin
                  long_sent[b] = 1'b1;
                  add_event(KIND_LONG_PRESS, b);
               end
            end
         end else if (is_down[b]) begin
            is_down[b] = 1'b0;
            if (in_bounce[b]) begin
               // release during bounce check keeps the counters
               in_bounce[b] = 1'b0;
            end else begin
               bounce_rem[b] = '0;
               held_ms[b]    = '0;
               if (long_sent[b]) begin
                  long_sent[b] = 1'b0;
                  add_event(KIND_LONG_CLICK, b);
               end
               add_event(KIND_CLICK, b);
            end
         end
         if (due_events.size() > first) due_events[due_events.size() - 1].last = 1'b1;
      endfunction

      function void check_event(logic [KIND_W-1:0] k, logic [BTN_W-1:0] b, logic l);
         event_type want;
         if (due_events.size() == 0) begin
            mismatches++;
            failures++;
            if (mismatches <= 10)
               $display("unexpected event: kind %0d button %0d last %0d", k, b, l);
         end else begin
            want = due_events.pop_front();
            if (k !== want.kind || b !== want.button || l !== want.last) begin
               mismatches++;
               failures++;
               if (mismatches <= 10)
                  $display("event mismatch: expected kind %0d button %0d last %0d, got %0d %0d %0d",
                     want.kind, want.button, want.last, k, b, l);
            end
         end
      endfunction

      function void close_out();
         if (due_events.size() != 0) begin
            $display("%0d expected events never arrived", due_events.size());
            failures += due_events.size();
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bdlp_req_if req_if ();
   bdlp_rsp_if rsp_if ();

   button_debounce_long_press uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   button_event_predictor sb;
   phase_plan_type plan[NUM_PHASES];
   int  sender_idle_pct = 0;
   int  receiver_stall_pct = 0;
   int  hold_asks = 0;
   int  holds_done = 0;
   int  hold_left = 0;
   int  quiet_cycles = 0;
   bit  level_now[NUM_BUTTONS];
   int  run_left[NUM_BUTTONS];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // receiver: long hold-offs on request, random stalls otherwise
   always @(posedge clock) begin
      if (holds_done != hold_asks) begin
         holds_done = holds_done + 1;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // note accepted samples and check accepted events
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready)
         sb.note_sample(req_if.button_index, req_if.pressed);
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_event(rsp_if.event_kind, rsp_if.event_button, rsp_if.last);
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic send_sample(input logic [BTN_W-1:0] b, input logic p);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.button_index <= b;
      req_if.pressed      <= p;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // samples for one button, oldest in bit zero
   task automatic run_pattern(input logic [BTN_W-1:0] b, input logic [15:0] bits, input int count);
      for (int k = 0; k < count; k++) send_sample(b, bits[k]);
   endtask

   // stop requesting until every event is back and the stage is empty
   task automatic wait_quiet();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (sb.due_events.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic program_regs(input int deb, input int sec, input int tick);
      logic [CSR_IDX_W-1:0]  regs[4];
      logic [CSR_DATA_W-1:0] words[4];
      logic [CSR_DATA_W-1:0] sec_word;
      logic [CSR_DATA_W-1:0] tick_word;
      sec_word = CSR_DATA_W'($urandom);
      sec_word[SEC_W-1:0] = SEC_W'(sec);
      tick_word = CSR_DATA_W'($urandom);
      tick_word[TICK_W-1:0] = TICK_W'(tick);
      regs  = '{CSR_DEBOUNCE_MS, CSR_LONG_PRESS_SEC, CSR_TICK_MS, CSR_UNUSED};
      words = '{CSR_DATA_W'(deb), sec_word, tick_word, CSR_DATA_W'($urandom)};
      csr_we <= 1'b1;
      for (int k = 0; k < 4; k++) begin
         csr_index <= regs[k];
         csr_wdata <= words[k];
         @(posedge clock);
         sb.write_reg(regs[k], words[k]);
      end
      csr_we <= 1'b0;
   endtask

   // pressed run length: short taps, runs just past the long threshold, or anything between
   function automatic int press_len(int deb, int sec, int tick);
      int to_confirm;
      int to_long;
      int pick;
      int len;
      if (tick == 0) begin
         to_confirm = (deb == 0) ? 2 : 40;
         to_long    = 0;
      end else begin
         to_confirm = 1 + ((deb <= tick) ? 1 : (deb + tick - 1) / tick);
         to_long    = (sec == 0) ? 0 : (sec * MS_PER_SEC + tick - 1) / tick;
      end
      pick = $urandom_range(0, 99);
      if (pick < 40)
         len = $urandom_range(1, to_confirm);
      else if (pick < 80)
         len = to_confirm + to_long + $urandom_range(0, 3);
      else
         len = $urandom_range(1, to_confirm + to_long + 3);
      return (len > MAX_PRESS) ? MAX_PRESS : len;
   endfunction

   initial begin
      int idx;
      int base;
      logic lvl;

      sb = new();
      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.button_index <= '0;
      req_if.pressed      <= 1'b0;
      csr_we              <= 1'b0;
      csr_index           <= CSR_DEBOUNCE_MS;
      csr_wdata           <= '0;
      foreach (level_now[k]) level_now[k] = 1'b0;

      plan[0] = '{20, 2, 10, 2, 95, IDLE_NONE};
      plan[1] = '{100, 255, 1023, 1, 400, IDLE_SENDER};
      plan[2] = '{65535, 1, 1023, 2, 95, IDLE_RECEIVER};
      plan[3] = '{35, 0, 7, 8, 95, IDLE_BOTH};
      plan[4] = '{0, 1, 1000, 8, 95, IDLE_NONE};
      plan[5] = '{1, 0, 1, 8, 95, IDLE_SENDER};
      plan[6] = '{10, 1, 333, 4, 95, IDLE_RECEIVER};
      plan[7] = '{$urandom_range(0, 60), $urandom_range(0, 2), $urandom_range(200, 1000),
                  8, 95, IDLE_BOTH};
      plan[8] = '{0, 1, 0, 4, 95, IDLE_NONE};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // bounce countdown, release during bounce, press, long press, long click and click
      wait_quiet();
      program_regs(1500, 1, 1000);
      run_pattern(3'd7, 16'b0_1111_1011, 9);
      run_pattern(3'd0, 16'b0, 1);
      // zero debounce with a zero tick, long press disabled
      wait_quiet();
      program_regs(0, 0, 0);
      run_pattern(3'd0, 16'b0111, 4);
      run_pattern(3'd3, 16'b01, 2);
      // widest debounce and long press settings
      wait_quiet();
      program_regs(65535, 255, 1023);
      run_pattern(3'd5, 16'b011, 3);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_quiet();
         program_regs(plan[ph].deb, plan[ph].sec, plan[ph].tick);
         case (plan[ph].idle)
            IDLE_NONE:     begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            IDLE_SENDER:   begin sender_idle_pct = 67; receiver_stall_pct = 0;  end
            IDLE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 67; end
            default:       begin sender_idle_pct = 21; receiver_stall_pct = 21; end
         endcase
         if (ph == PRESSURE_PH) hold_asks = hold_asks + 1;
         base = $urandom_range(0, NUM_BUTTONS - 1);
         foreach (run_left[k]) run_left[k] = 0;

         for (int n = 0; n < plan[ph].items; n++) begin
            if (n == plan[ph].items / 2) wait_quiet();
            idx = (base + $urandom_range(0, plan[ph].buttons - 1)) % NUM_BUTTONS;
            if ($urandom_range(0, 99) < NOISE_PCT) begin
               lvl = 1'($urandom_range(0, 1));
            end else begin
               // well-formed press and release runs per button
               if (run_left[idx] == 0) begin
                  level_now[idx] = !level_now[idx];
                  run_left[idx] = level_now[idx] ?
                     press_len(plan[ph].deb, plan[ph].sec, plan[ph].tick) :
                     $urandom_range(1, 4);
               end
               run_left[idx]--;
               lvl = level_now[idx];
            end
            send_sample(idx[BTN_W-1:0], lvl);
         end
      end

      wait_quiet();
      repeat (END_WAIT) @(posedge clock);
      sb.close_out();
      if (sb.failures == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

### sim.f
+incdir+design
design/bdlp_pkg.sv
design/bdlp_req_if.sv
design/bdlp_rsp_if.sv
design/button_debounce_long_press.sv
test/button_debounce_long_press_test.sv
